// ===== sv/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, fixed-point constants and types of the plasma pixel core.
// ----------------------------------------------------------------------------
package ppp_pkg;

  // port field widths
  localparam int COORD_W = 9;
  localparam int PHASE_W = 16;
  localparam int PIX_W   = 8;

  // angles are turns in Q0.16, the quadrant sits in the top two bits
  localparam int ANG_W       = 16;
  localparam int QUAD_FRAC_W = 14;

  // square root of (x*x + y*y) * 2^16, root in Q.8
  localparam int SQ_W        = 2 * COORD_W + 1;
  localparam int RAD_SHIFT   = 16;
  localparam int RAD_W       = 36;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int SQRT_DIGITS = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_DIGITS;

  // coordinate scaling, C = round(2^32 / (2*pi*k))
  localparam int C_W     = 28;
  localparam int PROD_W  = COORD_W + 1 + C_W;
  localparam int PROD4_W = ROOT_W + C_W;
  localparam logic [C_W-1:0] C_DIV7 = 28'd97652182;
  localparam logic [C_W-1:0] C_DIV5 = 28'd136713055;
  localparam logic [C_W-1:0] C_DIV6 = 28'd113927546;
  localparam logic [C_W-1:0] C_DIV4 = 28'd170891319;

  // sine table and wave levels
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int MAG_W  = 17;
  localparam int LVL_W  = 18;
  localparam int WAVE_W = 25;
  localparam int SUM_W  = 27;
  localparam int NUM_WAVES = 4;
  localparam logic [LVL_W-1:0] ONE_Q16 = 18'd65536;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd254;

  // total register stages from input to output register
  localparam int PIPE_STAGES = SQRT_STAGES + 7;

  // the three coordinate angles and the phase, carried while the root settles
  typedef struct packed {
    logic [ANG_W-1:0]   a1;
    logic [ANG_W-1:0]   a2;
    logic [ANG_W-1:0]   a3;
    logic [PHASE_W-1:0] phase;
  } ang_set_t;

endpackage

// ===== sv/ppp_isqrt.sv =====
// ----------------------------------------------------------------------------
// ppp_isqrt
// Pipelined integer square root, two root bits resolved per stage.
// ----------------------------------------------------------------------------
module ppp_isqrt
  import ppp_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic [ROOT_W-1:0] root_o
);

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  sqrt_st_t st_q [SQRT_STAGES];
  sqrt_st_t st_d [SQRT_STAGES];
  sqrt_st_t st_init;

  // one stage of the digit recurrence, radicand consumed msb first
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t         r;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    int               d;
    r = s;
    for (d = 0; d < SQRT_DIGITS; d++) begin
      cur   = {r.rem[REM_W-3:0], r.rad[RAD_W-1 -: 2]};
      trial = REM_W'({r.root, 2'b01});
      r.rad = r.rad << 2;
      if (cur >= trial) begin
        r.rem  = cur - trial;
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = cur;
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  assign st_init = '{rad: radicand_i, rem: '0, root: '0};

  // next value of every stage
  always_comb begin
    st_d[0] = sqrt_step(st_init);
    for (int i = 1; i < SQRT_STAGES; i++) begin
      st_d[i] = sqrt_step(st_q[i-1]);
    end
  end

  // stage registers, frozen together on a stall
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < SQRT_STAGES; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign root_o = st_q[SQRT_STAGES-1].root;

endmodule

// ===== sv/ppp_sine_rom.sv =====
// ----------------------------------------------------------------------------
// ppp_sine_rom
// Quarter-wave sine table in Q1.16 with a registered read port.
// ----------------------------------------------------------------------------
module ppp_sine_rom
  import ppp_pkg::*;
#(
  parameter int Depth = 1024
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [$clog2(Depth+1)-1:0]   addr_i,
  output logic [MAG_W-1:0]             data_o
);

  typedef logic [MAG_W-1:0] rom_arr_t [Depth+1];

  // sin(pi/2 * i/Depth) by a 7-term taylor series in Q2.30
  function automatic logic [MAG_W-1:0] sin_entry(int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(i) * HALF_PI_Q30 + 64'(Depth / 2)) / 64'(Depth);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    return MAG_W'((sum + 64'd8192) >> 14);
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int unsigned i = 0; i <= Depth; i++) begin
      r[i] = sin_entry(i);
    end
    return r;
  endfunction

  localparam rom_arr_t SineRom = build_rom();

  // registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= SineRom[addr_i];
    end
  end

endmodule

// ===== sv/plasma_pattern_pixel_core.sv =====
// ----------------------------------------------------------------------------
// plasma_pattern_pixel_core
// Grey plasma test pattern: four sine waves of column, row, diagonal and
// radius, each shifted by the frame phase, summed and scaled to 0..254.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, column_i, row_i, | to core
//          | frame_phase_i                            |
//  out     | out_valid_o, out_ready_i, intensity_o    | from core
//
//  One pixel per clock while the output is taken; the pipeline holds the
//  nine-stage radius square root (two root bits per stage).
//  rst_ni clears only the valid bits; no table fill is needed after reset.
//  When the output register holds a pixel that is not taken, the whole
//  pipeline freezes; in_ready_o = !out_valid_o || out_ready_i.
// ----------------------------------------------------------------------------
module plasma_pattern_pixel_core
  import ppp_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] column_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [PHASE_W-1:0] frame_phase_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PIX_W-1:0]   intensity_o
);

  localparam int AddrW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IdxProdW = QUAD_FRAC_W + AddrW;
  localparam int DlyLen   = SQRT_STAGES - 1;

  logic                   adv;
  logic [PIPE_STAGES-1:0] vld_q;

  // stage 1: inputs and squared radius
  logic [COORD_W-1:0] x1_q, y1_q;
  logic [PHASE_W-1:0] t1_q;
  logic [SQ_W-1:0]    sq_d, sq1_q;
  // stage 2: coordinate products
  logic [PROD_W-1:0]  pr1_q, pr2_q, pr3_q;
  logic [PHASE_W-1:0] t2_q;
  // stages 3 to 10: angles waiting for the root
  ang_set_t           dly_d;
  ang_set_t           dly_q [DlyLen];
  logic [ROOT_W-1:0]  root;
  // stage 11: radius product
  logic [PROD4_W-1:0] prod4_q;
  ang_set_t           ang11_q;
  // stage 12 to 16: table lookup and sum
  logic [ANG_W-1:0]   ang12_q [NUM_WAVES];
  logic [AddrW-1:0]   idx_d [NUM_WAVES];
  logic [AddrW-1:0]   idx13_q [NUM_WAVES];
  logic               neg13_q [NUM_WAVES];
  logic [MAG_W-1:0]   mag14 [NUM_WAVES];
  logic               neg14_q [NUM_WAVES];
  logic [WAVE_W-1:0]  wave_d [NUM_WAVES];
  logic [WAVE_W-1:0]  wave15_q [NUM_WAVES];
  logic [SUM_W-1:0]   sum_d;
  logic [PIX_W-1:0]   pix16_q;

  // pipeline moves unless a finished pixel waits at the output
  assign adv        = !vld_q[PIPE_STAGES-1] || out_ready_i;
  assign in_ready_o = adv;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_STAGES-2:0], in_valid_i && in_ready_o};
    end
  end

  // squared distance from the origin
  assign sq_d = SQ_W'(column_i) * SQ_W'(column_i) + SQ_W'(row_i) * SQ_W'(row_i);

  // coordinate angles, rounded from turns in Q.32 products
  always_comb begin
    dly_d.a1    = ANG_W'((pr1_q + (PROD_W'(1) << 15)) >> 16) + t2_q;
    dly_d.a2    = ANG_W'((pr2_q + (PROD_W'(1) << 15)) >> 16) - t2_q;
    dly_d.a3    = ANG_W'((pr3_q + (PROD_W'(1) << 15)) >> 16) - t2_q;
    dly_d.phase = t2_q;
  end

  // front stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q  <= column_i;
      y1_q  <= row_i;
      t1_q  <= frame_phase_i;
      sq1_q <= sq_d;
      pr1_q <= PROD_W'(x1_q) * PROD_W'(C_DIV7);
      pr2_q <= PROD_W'(y1_q) * PROD_W'(C_DIV5);
      pr3_q <= (PROD_W'(x1_q) + PROD_W'(y1_q)) * PROD_W'(C_DIV6);
      t2_q  <= t1_q;
      dly_q[0] <= dly_d;
      for (int i = 1; i < DlyLen; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // radius in Q.8
  ppp_isqrt u_isqrt (
    .clk_i      (clk_i),
    .en_i       (adv),
    .radicand_i (RAD_W'(sq1_q) << RAD_SHIFT),
    .root_o     (root)
  );

  // radius angle, then all four angles side by side
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod4_q    <= PROD4_W'(root) * PROD4_W'(C_DIV4);
      ang11_q    <= dly_q[DlyLen-1];
      ang12_q[0] <= ang11_q.a1;
      ang12_q[1] <= ang11_q.a2;
      ang12_q[2] <= ang11_q.a3;
      ang12_q[3] <= ANG_W'((prod4_q + (PROD4_W'(1) << 23)) >> 24) - ang11_q.phase;
    end
  end

  // quarter-wave table index: mirror in odd quadrants
  always_comb begin
    for (int w = 0; w < NUM_WAVES; w++) begin
      logic [IdxProdW-1:0] pprod;
      logic [AddrW-1:0]    p;
      pprod = IdxProdW'(ang12_q[w][QUAD_FRAC_W-1:0]) * IdxProdW'(SINE_TABLE_DEPTH);
      p     = AddrW'(pprod >> QUAD_FRAC_W);
      idx_d[w] = ang12_q[w][ANG_W-2] ? (AddrW'(SINE_TABLE_DEPTH) - p) : p;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int w = 0; w < NUM_WAVES; w++) begin
        idx13_q[w] <= idx_d[w];
        neg13_q[w] <= ang12_q[w][ANG_W-1];
        neg14_q[w] <= neg13_q[w];
      end
    end
  end

  // one table per wave
  for (genvar g = 0; g < NUM_WAVES; g++) begin : g_rom
    ppp_sine_rom #(
      .Depth (SINE_TABLE_DEPTH)
    ) u_rom (
      .clk_i  (clk_i),
      .en_i   (adv),
      .addr_i (idx13_q[g]),
      .data_o (mag14[g])
    );
  end

  // wave level 127 * (1 +/- sin) and the sum of the four
  always_comb begin
    for (int w = 0; w < NUM_WAVES; w++) begin
      logic [LVL_W-1:0] lvl;
      lvl = neg14_q[w] ? (ONE_Q16 - LVL_W'(mag14[w])) : (ONE_Q16 + LVL_W'(mag14[w]));
      wave_d[w] = (WAVE_W'(lvl) << 7) - WAVE_W'(lvl);
    end
    sum_d = '0;
    for (int w = 0; w < NUM_WAVES; w++) begin
      sum_d = sum_d + SUM_W'(wave15_q[w]);
    end
  end

  // wave registers and output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int w = 0; w < NUM_WAVES; w++) begin
        wave15_q[w] <= wave_d[w];
      end
      pix16_q <= PIX_W'(sum_d >> 18);
    end
  end

  assign out_valid_o = vld_q[PIPE_STAGES-1];
  assign intensity_o = pix16_q;

`ifndef SYNTHESIS
  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // a transfer in always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted pixel lost at pipeline entry");

  // no pixel appears at the output from an empty stage before it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !vld_q[PIPE_STAGES-2]) |=> !out_valid_o)
    else $error("output valid without a pixel behind it");

  // sum of four waves never exceeds the peak value
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (intensity_o <= PIX_MAX))
    else $error("intensity above peak");
`endif

endmodule
